[sv/scale_degree_pitch_mapper_top_defines.svh]
// Assertion macros shared by the scale degree pitch mapper RTL.
`ifndef SCALE_DEGREE_PITCH_MAPPER_TOP_DEFINES_SVH
`define SCALE_DEGREE_PITCH_MAPPER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define SDPM_ASSERT_IMPLIES(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("sdpm assertion failed");

// Condition must hold after the trigger, delayed by the dly argument.
`define SDPM_ASSERT_DELAY(label, clk, rst, trig, dly, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cond)) \
    else $error("sdpm assertion failed");

`endif

[sv/sdpm_pkg.sv]
// Types, constants and helpers for the scale degree pitch mapper.
package sdpm_pkg;

  // Field widths
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 23;
  localparam int PERIOD_W = 8;
  localparam int SIZE_W   = 5;
  localparam int CFG_W    = 64;
  localparam int KEY_W    = 8;
  localparam int KEY_SLOTS = 16;
  localparam int KEY_IDX_W = 4;
  localparam int PROD_W   = PERIOD_W + VALUE_W;

  // Default for the MAX_KEYS parameter
  localparam int MAX_KEYS_DEFAULT = 16;

  // Divider layout: 16 quotient bits, 4 per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = VALUE_W / DIV_STAGES;

  // Saturation limit for degree-to-pitch results
  localparam logic [PROD_W-1:0] RESULT_MAX = PROD_W'(4194303);

  // Register indexes
  localparam logic [1:0] REG_PERIOD     = 2'd0;
  localparam logic [1:0] REG_SCALE_SIZE = 2'd1;
  localparam logic [1:0] REG_KEYS_LOW   = 2'd2;
  localparam logic [1:0] REG_KEYS_HIGH  = 2'd3;

  // Commands
  localparam logic CMD_DEG_TO_PITCH = 1'b0;
  localparam logic CMD_PITCH_TO_IDX = 1'b1;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd12;
  localparam logic [SIZE_W-1:0]   SCALE_SIZE_RST = 5'd12;
  localparam logic [CFG_W-1:0]    KEYS_LOW_RST   = 64'h0706_0504_0302_0100;
  localparam logic [CFG_W-1:0]    KEYS_HIGH_RST  = 64'h0000_0000_0B0A_0908;

  // One divider pipeline slot
  typedef struct packed {
    logic                cmd;
    logic                one_octave;
    logic                neg;
    logic [PERIOD_W-1:0] divisor;
    logic [PERIOD_W-1:0] rem;
    logic [VALUE_W-1:0]  dvd;   // dividend shifting out, quotient shifting in
  } div_slot_t;

  // One restoring division step
  function automatic div_slot_t div_step(input div_slot_t s);
    div_slot_t        r;
    logic [PERIOD_W:0] trial;
    r = s;
    trial = {s.rem, s.dvd[VALUE_W-1]};
    if (trial >= {1'b0, s.divisor}) begin
      r.rem = PERIOD_W'(trial - {1'b0, s.divisor});
      r.dvd = {s.dvd[VALUE_W-2:0], 1'b1};
    end else begin
      r.rem = trial[PERIOD_W-1:0];
      r.dvd = {s.dvd[VALUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[sv/scale_degree_pitch_mapper_top.sv]
// Scale degree to pitch mapper: 7 register stages from command to result.
// done and the result are registered behind the input slot, the divider stages and the post stage.
// Throughput: one transaction per cycle, set by the 4-stage radix-16 divider.
// busy follows rst; the receiver cannot stall, so the pipeline never waits.
// Reset clears the pipeline valid bits and loads the register defaults (period 12, size 12).
`include "scale_degree_pitch_mapper_top_defines.svh"

module scale_degree_pitch_mapper_top #(
  parameter int MAX_KEYS = sdpm_pkg::MAX_KEYS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic signed [sdpm_pkg::VALUE_W-1:0]  value,
  input  logic                          one_octave,
  // result channel
  output logic                          done,
  output logic signed [sdpm_pkg::RESULT_W-1:0] result_value,
  output logic                          in_scale,
  output logic                          bad_input,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [sdpm_pkg::CFG_W-1:0]    cfg_data
);
  import sdpm_pkg::*;

  localparam int LATENCY = DIV_STAGES + 3;

  // Configuration registers
  logic [PERIOD_W-1:0] period;
  logic [SIZE_W-1:0]   scale_size;
  logic [CFG_W-1:0]    keys_low;
  logic [CFG_W-1:0]    keys_high;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RST;
      scale_size <= SCALE_SIZE_RST;
      keys_low   <= KEYS_LOW_RST;
      keys_high  <= KEYS_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PERIOD:     period     <= cfg_data[PERIOD_W-1:0];
        REG_SCALE_SIZE: scale_size <= cfg_data[SIZE_W-1:0];
        REG_KEYS_LOW:   keys_low   <= cfg_data;
        REG_KEYS_HIGH:  keys_high  <= cfg_data;
      endcase
    end
  end

  // Effective period and scale size
  logic [PERIOD_W-1:0] p_eff;
  logic [SIZE_W-1:0]   n_eff;
  assign p_eff = (period == '0) ? PERIOD_W'(1) : period;

  always_comb begin
    if (scale_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (scale_size > SIZE_W'(MAX_KEYS)) begin
      n_eff = SIZE_W'(MAX_KEYS);
    end else begin
      n_eff = scale_size;
    end
  end

  // Unpacked key table
  logic [KEY_W-1:0] keys [KEY_SLOTS];
  always_comb begin
    for (int i = 0; i < KEY_SLOTS / 2; i++) begin
      keys[i]                 = keys_low[i*KEY_W +: KEY_W];
      keys[i + KEY_SLOTS / 2] = keys_high[i*KEY_W +: KEY_W];
    end
  end

  // Input stage: magnitude and divisor selection
  logic      accept;
  div_slot_t in_slot;
  assign accept = start && !busy;

  always_comb begin
    in_slot            = '0;
    in_slot.cmd        = cmd;
    in_slot.one_octave = one_octave;
    in_slot.neg        = value[VALUE_W-1];
    in_slot.dvd        = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
    in_slot.divisor    = (cmd == CMD_PITCH_TO_IDX) ? p_eff : PERIOD_W'(n_eff);
  end

  // Divider pipeline: slot 0 is the input register, each later slot 4 steps
  div_slot_t slot  [DIV_STAGES+1];
  logic      vld   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    slot[0] <= in_slot;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_slot_t step_out;

    always_comb begin
      step_out = slot[g];
      for (int b = 0; b < DIV_BITS; b++) begin
        step_out = div_step(step_out);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      slot[g+1] <= step_out;
    end
  end

  // Post stage: key fetch and octave product, or wrapped pitch match
  div_slot_t             dq;
  logic [PERIOD_W-1:0]   wrapped;
  logic [KEY_SLOTS-1:0]  match_next;
  assign dq = slot[DIV_STAGES];
  assign wrapped = (dq.neg && dq.rem != '0) ? PERIOD_W'(p_eff - dq.rem) : dq.rem;

  always_comb begin
    match_next = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match_next[i] = (i < MAX_KEYS) && (SIZE_W'(i) < n_eff) && (keys[i] == wrapped);
    end
  end

  logic                 post_vld;
  logic                 post_cmd;
  logic                 post_bad;
  logic                 post_one_octave;
  logic [KEY_W-1:0]     post_key;
  logic [PROD_W-1:0]    post_prod;
  logic [KEY_SLOTS-1:0] post_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      post_vld <= 1'b0;
    end else begin
      post_vld <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    post_cmd        <= dq.cmd;
    post_bad        <= (dq.cmd == CMD_DEG_TO_PITCH) && dq.neg;
    post_one_octave <= dq.one_octave;
    post_key        <= keys[dq.rem[KEY_IDX_W-1:0]];
    post_prod       <= PROD_W'(p_eff) * PROD_W'(dq.dvd);
    post_match      <= match_next;
  end

  // Output stage: add and saturate (zero for a negative degree), or priority-encode the first match
  logic [PROD_W-1:0]    pitch_sum;
  logic [KEY_IDX_W-1:0] first_idx;
  logic                 found;
  logic [RESULT_W-1:0]  result_next;

  assign pitch_sum = PROD_W'(post_key) + (post_one_octave ? '0 : post_prod);
  assign found     = |post_match;

  always_comb begin
    first_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (post_match[i]) begin
        first_idx = KEY_IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (post_cmd == CMD_PITCH_TO_IDX) begin
      result_next = found ? RESULT_W'(first_idx) : '1;
    end else if (post_bad) begin
      result_next = '0;
    end else if (pitch_sum > RESULT_MAX) begin
      result_next = RESULT_MAX[RESULT_W-1:0];
    end else begin
      result_next = pitch_sum[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= post_vld;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= result_next;
    in_scale     <= (post_cmd == CMD_PITCH_TO_IDX) && found;
    bad_input    <= post_bad;
  end

  // Checks
  `SDPM_ASSERT_DELAY(a_latency, clk, rst, accept, LATENCY, done)
  `SDPM_ASSERT_IMPLIES(a_flags_excl, clk, rst, done, !(in_scale && bad_input))
  `SDPM_ASSERT_IMPLIES(a_bad_zero, clk, rst, done && bad_input, result_value == '0)
  `SDPM_ASSERT_IMPLIES(a_idx_range, clk, rst, done && in_scale, $unsigned(result_value) < MAX_KEYS)

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the scale degree to pitch mapper: random traffic, scoreboard.
module tb_top;
  import sdpm_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 12;    // pipeline is 7 deep, plus margin
  localparam int RAND_PHASES  = 10;
  localparam int NOTES_PER_PHASE = 70;

  typedef struct packed {
    logic                       cmd;
    logic signed [VALUE_W-1:0]  value;
    logic                       one_octave;
  } note_req_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic                       in_scale;
    logic                       bad_input;
  } note_res_t;

  // DUT signals
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       cmd = 1'b0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       one_octave = 1'b0;
  logic                       done;
  logic signed [RESULT_W-1:0] result_value;
  logic                       in_scale;
  logic                       bad_input;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = REG_PERIOD;
  logic [CFG_W-1:0]           cfg_data = '0;

  // Mirror of the configuration registers
  logic [PERIOD_W-1:0] period_reg = PERIOD_RST;
  logic [SIZE_W-1:0]   size_reg   = SCALE_SIZE_RST;
  logic [CFG_W-1:0]    keys_lo    = KEYS_LOW_RST;
  logic [CFG_W-1:0]    keys_hi    = KEYS_HIGH_RST;

  note_req_t note_pending_q[$];
  note_res_t mapped_q[$];
  note_req_t cur_note;
  int        idle_left = 0;
  logic      steady_phase = 1'b0;

  int fail_count = 0;
  int mismatch_count = 0;
  int notes_checked = 0;
  int cfg_writes = 0;
  int phases_run = 0;
  int hits_in_scale = 0;
  int bad_degrees = 0;
  int saturated = 0;
  int stall_cycles = 0;

  scale_degree_pitch_mapper_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .value        (value),
    .one_octave   (one_octave),
    .done         (done),
    .result_value (result_value),
    .in_scale     (in_scale),
    .bad_input    (bad_input),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Key offset byte from the mirrored table
  function automatic int key_byte(input int idx);
    logic [CFG_W-1:0] word;
    word = (idx < 8) ? keys_lo : keys_hi;
    return int'(word[(idx % 8) * KEY_W +: KEY_W]);
  endfunction

  // Expected mapping for one note under the current configuration
  function automatic note_res_t map_note(input note_req_t req);
    note_res_t r;
    int        p, n, d, pitch, m;
    logic      found;
    r = '0;
    found = 1'b0;
    p = (period_reg == 0) ? 1 : int'(period_reg);
    n = (size_reg == 0) ? 1 : ((size_reg > MAX_KEYS_DEFAULT) ? MAX_KEYS_DEFAULT : int'(size_reg));
    if (req.cmd == CMD_DEG_TO_PITCH) begin
      if (req.value < 0) begin
        r.bad_input = 1'b1;
      end else begin
        d = int'(req.value);
        pitch = key_byte(d % n);
        if (!req.one_octave) pitch += p * (d / n);
        if (pitch > int'(RESULT_MAX)) pitch = int'(RESULT_MAX);
        r.result_value = RESULT_W'(pitch);
      end
    end else begin
      // truncating remainder, then fold negatives into 0..p-1
      m = int'(req.value) % p;
      if (m < 0) m += p;
      r.result_value = '1;
      for (int i = 0; i < n; i++) begin
        if (!found && key_byte(i) == m) begin
          found = 1'b1;
          r.result_value = RESULT_W'(i);
          r.in_scale = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Sender idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Driver: present queued notes on the command channel
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) mapped_q.push_back(map_note(cur_note));
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (note_pending_q.size() != 0) begin
        cur_note = note_pending_q.pop_front();
        start <= 1'b1;
        cmd <= cur_note.cmd;
        value <= cur_note.value;
        one_octave <= cur_note.one_octave;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    note_res_t want;
    if (!rst && done) begin
      if (mapped_q.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("ERROR: result with nothing expected: value=%0d in_scale=%0b bad=%0b",
                   result_value, in_scale, bad_input);
        mismatch_count++;
      end else begin
        want = mapped_q.pop_front();
        notes_checked++;
        if (want.in_scale) hits_in_scale++;
        if (want.bad_input) bad_degrees++;
        if (!want.in_scale && want.result_value == RESULT_W'(RESULT_MAX)) saturated++;
        if (result_value !== want.result_value || in_scale !== want.in_scale ||
            bad_input !== want.bad_input) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("ERROR: result %0d: exp value=%0d in_scale=%0b bad=%0b, got %0d %0b %0b",
                     notes_checked, want.result_value, want.in_scale, want.bad_input,
                     result_value, in_scale, bad_input);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One register write over the config channel; mirror updated at the handshake
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_PERIOD:     period_reg = data[PERIOD_W-1:0];
      REG_SCALE_SIZE: size_reg = data[SIZE_W-1:0];
      REG_KEYS_LOW:   keys_lo = data;
      REG_KEYS_HIGH:  keys_hi = data;
      default: ;
    endcase
  endtask

  // Hold the sender until the queue is empty and every result is in
  task automatic wait_drain();
    while (note_pending_q.size() != 0 || start || mapped_q.size() != 0) @(posedge clk);
    phases_run++;
  endtask

  task automatic add_note(input logic c, input int v, input logic oo);
    note_req_t req;
    req.cmd = c;
    req.value = VALUE_W'(v);
    req.one_octave = oo;
    note_pending_q.push_back(req);
  endtask

  function automatic logic [CFG_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random configuration, keys mostly below the period so lookups hit
  task automatic rand_config();
    logic [CFG_W-1:0] w;
    int               p, r;
    r = $urandom_range(0, 9);
    case (r)
      0:       p = (($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 2) == 0) ? 1 :
                   (($urandom_range(0, 1) == 0) ? 128 : 255)));
      1, 2, 3, 4: p = $urandom_range(2, 24);
      default: p = $urandom_range(0, 255);
    endcase
    w = rand_word();
    w[PERIOD_W-1:0] = PERIOD_W'(p);
    if ($urandom_range(0, 3) != 0 || phases_run < 3) write_reg(REG_PERIOD, w);
    w = rand_word();
    case ($urandom_range(0, 7))
      0:       w[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 1) ? 0 : 31);
      1:       w[SIZE_W-1:0] = SIZE_W'($urandom_range(16, 31));
      default: w[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(REG_SCALE_SIZE, w);
    p = (period_reg == 0) ? 1 : int'(period_reg);
    w = rand_word();
    for (int b = 0; b < 8; b++)
      if ($urandom_range(0, 99) < 85) w[b*KEY_W +: KEY_W] = KEY_W'($urandom_range(0, p - 1));
    write_reg(REG_KEYS_LOW, w);
    w = rand_word();
    for (int b = 0; b < 8; b++)
      if ($urandom_range(0, 99) < 85) w[b*KEY_W +: KEY_W] = KEY_W'($urandom_range(0, p - 1));
    if ($urandom_range(0, 3) != 0) write_reg(REG_KEYS_HIGH, w);
  endtask

  task automatic rand_notes(input int count);
    int v;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom_range(0, 600) - 300;
        4, 5, 6:    v = int'($signed(VALUE_W'($urandom)));
        7: begin
          case ($urandom_range(0, 3))
            0:       v = -32768;
            1:       v = -1;
            2:       v = 0;
            default: v = 32767;
          endcase
        end
        default:    v = $urandom_range(0, 32767);
      endcase
      add_note(1'($urandom), v, 1'($urandom));
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: chromatic 12-step table, everything in scale
    add_note(CMD_DEG_TO_PITCH, 0, 1'b0);
    add_note(CMD_DEG_TO_PITCH, 32767, 1'b0);
    add_note(CMD_DEG_TO_PITCH, 32767, 1'b1);
    add_note(CMD_DEG_TO_PITCH, -1, 1'b0);
    add_note(CMD_DEG_TO_PITCH, -32768, 1'b1);
    add_note(CMD_PITCH_TO_IDX, -1, 1'b0);
    add_note(CMD_PITCH_TO_IDX, -32768, 1'b0);
    add_note(CMD_PITCH_TO_IDX, 32767, 1'b1);
    wait_drain();

    // Major scale; entry 7 holds 1 but lies past the scale size
    write_reg(REG_PERIOD, 64'd12);
    write_reg(REG_SCALE_SIZE, 64'd7);
    write_reg(REG_KEYS_LOW, 64'h010B_0907_0504_0200);
    write_reg(REG_KEYS_HIGH, 64'h0);
    add_note(CMD_PITCH_TO_IDX, 1, 1'b0);
    add_note(CMD_PITCH_TO_IDX, -13, 1'b0);
    add_note(CMD_DEG_TO_PITCH, 14, 1'b0);
    add_note(CMD_DEG_TO_PITCH, 13, 1'b1);
    wait_drain();

    // Zero period and zero size both act as one; key 3 never matches period one
    write_reg(REG_PERIOD, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(REG_SCALE_SIZE, 64'hFFFF_FFFF_FFFF_FFE0);
    write_reg(REG_KEYS_LOW, 64'h0000_0000_0000_0003);
    add_note(CMD_DEG_TO_PITCH, 5, 1'b0);
    add_note(CMD_PITCH_TO_IDX, -7, 1'b0);
    wait_drain();

    // Widest period, one key at 255: saturation and a key that cannot match
    write_reg(REG_PERIOD, 64'd255);
    write_reg(REG_SCALE_SIZE, 64'd1);
    write_reg(REG_KEYS_LOW, 64'h0000_0000_0000_00FF);
    add_note(CMD_DEG_TO_PITCH, 32767, 1'b0);
    add_note(CMD_PITCH_TO_IDX, -1, 1'b0);
    add_note(CMD_PITCH_TO_IDX, 255, 1'b0);
    wait_drain();

    // Size above the slot count clamps to 16; last slot reached
    write_reg(REG_PERIOD, 64'd200);
    write_reg(REG_SCALE_SIZE, 64'd31);
    write_reg(REG_KEYS_HIGH, 64'hC7C8_C9CA_CBCC_CDCE);
    add_note(CMD_PITCH_TO_IDX, -1, 1'b0);
    add_note(CMD_DEG_TO_PITCH, 31, 1'b0);
    wait_drain();

    // Random phases, every third one with back-to-back commands
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      rand_config();
      steady_phase = (ph % 3 == 1);
      rand_notes(NOTES_PER_PHASE);
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mapped_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", mapped_q.size());
      fail_count += mapped_q.size();
    end
    $display("Run: %0d transactions checked over %0d configuration phases, %0d register writes",
             notes_checked, phases_run, cfg_writes);
    $display("Seen: %0d in-scale lookups, %0d negative degrees, %0d saturated pitches, %0d errors",
             hits_in_scale, bad_degrees, saturated, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/sdpm_pkg.sv
sv/scale_degree_pitch_mapper_top.sv
sim/tb_top.sv
